// ===== rtl/button_pwm_frequency_selector_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the button PWM frequency selector
// Clocked property checks with a reset guard; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PWM_FREQUENCY_SELECTOR_CORE_ASSERT_SVH
`define BUTTON_PWM_FREQUENCY_SELECTOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked at every rising edge while reset is released.
`define BPFS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bpfs assertion failed");
// Implication checked at every rising edge while reset is released.
`define BPFS_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    `BPFS_ASSERT(label, clk, rst_n, (cond) |-> (prop))
`else
`define BPFS_ASSERT(label, clk, rst_n, prop)
`define BPFS_ASSERT_IMPL(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== rtl/bpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfs_pkg
// Types, register codes and the button debouncer step for the selector core.
// ----------------------------------------------------------------------------
package bpfs_pkg;

    localparam int unsigned CNT_W     = 16;
    localparam int unsigned PERIOD_W  = 16;
    localparam int unsigned CMP_W     = 15;
    localparam int unsigned IDX_W     = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned NUM_BTN   = 3;
    localparam int unsigned NUM_FREQ  = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_3     = 3'd4;

    // Reset values of the registers.
    localparam logic [CNT_W-1:0]    RST_SAMPLE_COUNT = 16'd10;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_0     = 16'd65454;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_1     = 16'd6545;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_2     = 16'd1309;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_3     = 16'd654;

    // Button slots.
    localparam logic [1:0] BTN_START = 2'd0;
    localparam logic [1:0] BTN_NEXT  = 2'd1;
    localparam logic [1:0] BTN_PREV  = 2'd2;

    localparam logic [IDX_W-1:0] IDX_MIN = 2'd0;
    localparam logic [IDX_W-1:0] IDX_MAX = 2'd3;

    typedef enum logic [1:0] {
        RUN_IDLE  = 2'd0,
        RUN_START = 2'd1,
        RUN_STOP  = 2'd2
    } t_run_phase;

    typedef enum logic {
        SEL_CHECK = 1'b0,
        SEL_LOAD  = 1'b1
    } t_sel_phase;

    typedef struct packed {
        logic [CNT_W-1:0] high_run;
        logic [CNT_W-1:0] low_run;
        logic             awaiting_low;
    } t_deb_state;

    typedef struct packed {
        t_deb_state state;
        logic       pulse;
    } t_deb_result;

    typedef struct packed {
        logic                output_enable;
        logic [IDX_W-1:0]    freq_index;
        logic [PERIOD_W-1:0] pwm_period;
        logic [CMP_W-1:0]    pwm_compare;
    } t_result;

    // One sample of a counter debouncer. The pulse marks the end of a stable
    // low run that followed a stable high run.
    function automatic t_deb_result deb_sample(
        input t_deb_state       cur,
        input logic             level,
        input logic [CNT_W-1:0] lim
    );
        t_deb_result res;
        res.state = cur;
        res.pulse = 1'b0;
        if (!level) begin
            res.state.low_run  = (cur.low_run >= lim) ? lim : cur.low_run + 16'd1;
            res.state.high_run = '0;
        end else begin
            res.state.high_run = (cur.high_run >= lim) ? lim : cur.high_run + 16'd1;
            res.state.low_run  = '0;
        end
        if (!cur.awaiting_low) begin
            if (res.state.high_run == lim) begin
                res.state.awaiting_low = 1'b1;
            end
        end else if (res.state.low_run == lim) begin
            res.state.awaiting_low = 1'b0;
            res.pulse              = 1'b1;
        end
        return res;
    endfunction

endpackage

// ===== rtl/button_pwm_frequency_selector_core.sv =====
// ----------------------------------------------------------------------------
// button_pwm_frequency_selector_core
// Debounces three active-low buttons, toggles the output enable and steps the
// PWM frequency index, loading period and half-period compare values.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     start, next, prev levels
//  output    out        o_out_valid / i_out_stall   enable, index, period, compare
//  config    in         i_cfg_we                    i_cfg_index, i_cfg_data
//
// One input beat per cycle while o_in_stall is low; each beat gives its result beat
// through the single state update into the output entry, or the skid entry if stalled.
// Reset is synchronous and resets all state but the output data registers at once; no sweep is needed.
// A two-entry output buffer lets a beat be accepted while the result waits;
// the input stall rises only when the second entry is full.
// ----------------------------------------------------------------------------
`include "button_pwm_frequency_selector_core_assert.svh"

module button_pwm_frequency_selector_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_start_level,
    input  logic                              i_next_level,
    input  logic                              i_prev_level,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_output_enable,
    output logic [bpfs_pkg::IDX_W-1:0]        o_freq_index,
    output logic [bpfs_pkg::PERIOD_W-1:0]     o_pwm_period,
    output logic [bpfs_pkg::CMP_W-1:0]        o_pwm_compare,
    input  logic                              i_cfg_we,
    input  logic [bpfs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bpfs_pkg::CFG_W-1:0]        i_cfg_data
);
    import bpfs_pkg::*;

    // Configuration registers.
    logic [CNT_W-1:0]    r_sample_count;
    logic [PERIOD_W-1:0] r_cfg_period [NUM_FREQ];

    // Block state.
    t_deb_state          r_deb [NUM_BTN];
    t_deb_state          n_deb [NUM_BTN];
    t_run_phase          r_run_phase, n_run_phase;
    t_sel_phase          r_sel_phase, n_sel_phase;
    logic [IDX_W-1:0]    r_freq_index, n_freq_index;
    logic                r_enable, n_enable;
    logic [PERIOD_W-1:0] r_pwm_period, n_pwm_period;
    logic [CMP_W-1:0]    r_pwm_compare, n_pwm_compare;

    // Output buffer.
    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;

    logic             in_accept;
    logic             out_free;
    logic [CNT_W-1:0] lim;
    t_deb_result      deb_start, deb_next, deb_prev;
    t_result          result;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign out_free  = !r_out_valid || !i_out_stall;

    // A sample count of zero behaves as one.
    assign lim = (r_sample_count == '0) ? 16'd1 : r_sample_count;

    assign deb_start = deb_sample(r_deb[BTN_START], i_start_level, lim);
    assign deb_next  = deb_sample(r_deb[BTN_NEXT], i_next_level, lim);
    assign deb_prev  = deb_sample(r_deb[BTN_PREV], i_prev_level, lim);

    always_comb begin
        for (int b = 0; b < NUM_BTN; b++) begin
            n_deb[b] = r_deb[b];
        end
        n_run_phase   = r_run_phase;
        n_sel_phase   = r_sel_phase;
        n_freq_index  = r_freq_index;
        n_enable      = r_enable;
        n_pwm_period  = r_pwm_period;
        n_pwm_compare = r_pwm_compare;

        // The start debouncer advances only in the phases that sample it.
        unique case (r_run_phase)
            RUN_IDLE: begin
                n_deb[BTN_START] = deb_start.state;
                if (deb_start.pulse) begin
                    n_run_phase = RUN_START;
                end
            end
            RUN_START: begin
                n_enable    = 1'b1;
                n_run_phase = RUN_STOP;
            end
            RUN_STOP: begin
                n_deb[BTN_START] = deb_start.state;
                if (deb_start.pulse) begin
                    n_enable    = 1'b0;
                    n_run_phase = RUN_IDLE;
                end
            end
            default: begin
                n_run_phase = RUN_IDLE;
            end
        endcase

        // Previous is sampled only when next did not fire.
        unique case (r_sel_phase)
            SEL_CHECK: begin
                n_deb[BTN_NEXT] = deb_next.state;
                if (deb_next.pulse) begin
                    if (r_freq_index != IDX_MAX) begin
                        n_freq_index = r_freq_index + 2'd1;
                    end
                    n_sel_phase = SEL_LOAD;
                end else begin
                    n_deb[BTN_PREV] = deb_prev.state;
                    if (deb_prev.pulse) begin
                        if (r_freq_index != IDX_MIN) begin
                            n_freq_index = r_freq_index - 2'd1;
                        end
                        n_sel_phase = SEL_LOAD;
                    end
                end
            end
            SEL_LOAD: begin
                n_pwm_period  = r_cfg_period[r_freq_index];
                n_pwm_compare = n_pwm_period[PERIOD_W-1:1];
                n_sel_phase   = SEL_CHECK;
            end
            default: begin
                n_sel_phase = SEL_CHECK;
            end
        endcase

        result.output_enable = n_enable;
        result.freq_index    = n_freq_index;
        result.pwm_period    = n_pwm_period;
        result.pwm_compare   = n_pwm_compare;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count  <= RST_SAMPLE_COUNT;
            r_cfg_period[0] <= RST_PERIOD_0;
            r_cfg_period[1] <= RST_PERIOD_1;
            r_cfg_period[2] <= RST_PERIOD_2;
            r_cfg_period[3] <= RST_PERIOD_3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_COUNT: r_sample_count  <= i_cfg_data;
                CFG_PERIOD_0:     r_cfg_period[0] <= i_cfg_data;
                CFG_PERIOD_1:     r_cfg_period[1] <= i_cfg_data;
                CFG_PERIOD_2:     r_cfg_period[2] <= i_cfg_data;
                CFG_PERIOD_3:     r_cfg_period[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < NUM_BTN; b++) begin
                r_deb[b].high_run     <= '0;
                r_deb[b].low_run      <= '0;
                r_deb[b].awaiting_low <= 1'b1;
            end
            r_run_phase   <= RUN_IDLE;
            r_sel_phase   <= SEL_CHECK;
            r_freq_index  <= IDX_MIN;
            r_enable      <= 1'b0;
            r_pwm_period  <= RST_PERIOD_0;
            r_pwm_compare <= '0;
        end else if (in_accept) begin
            for (int b = 0; b < NUM_BTN; b++) begin
                r_deb[b] <= n_deb[b];
            end
            r_run_phase   <= n_run_phase;
            r_sel_phase   <= n_sel_phase;
            r_freq_index  <= n_freq_index;
            r_enable      <= n_enable;
            r_pwm_period  <= n_pwm_period;
            r_pwm_compare <= n_pwm_compare;
        end
    end

    // The skid entry fills only while the output entry is stalled, and drains
    // into it first, so beats leave in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= result;
            end
        end else if (in_accept) begin
            r_skid <= result;
        end
    end

    assign o_in_stall      = r_skid_valid;
    assign o_out_valid     = r_out_valid;
    assign o_output_enable = r_out.output_enable;
    assign o_freq_index    = r_out.freq_index;
    assign o_pwm_period    = r_out.pwm_period;
    assign o_pwm_compare   = r_out.pwm_compare;

    `BPFS_ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `BPFS_ASSERT_IMPL(a_enable_from_start, i_clk, i_rst_n, $rose(r_enable),
        $past(r_run_phase) == RUN_START)
    `BPFS_ASSERT_IMPL(a_index_in_check, i_clk, i_rst_n,
        r_freq_index != $past(r_freq_index), $past(r_sel_phase) == SEL_CHECK)
    `BPFS_ASSERT_IMPL(a_period_in_load, i_clk, i_rst_n,
        r_pwm_period != $past(r_pwm_period), $past(r_sel_phase) == SEL_LOAD)

endmodule
